// ===== rtl/mfbp_pkg.sv =====
// Package for the MSB-first bit-field packer: widths, item kind codes and the
// command word passed from the front end to the back end. No dependencies.
package mfbp_pkg;

	// Field widths of the item and result channels
	localparam int KIND_W  = 2;
	localparam int VALUE_W = 32;
	localparam int WIDTH_W = 6;
	localparam int BYTE_W  = 8;
	localparam int POS_W   = 3;

	// Widest bit field accepted; larger counts saturate
	localparam int MAX_FIELD_BITS = 32;
	localparam int FIELD_LIMIT    = (MAX_FIELD_BITS < VALUE_W) ? MAX_FIELD_BITS : VALUE_W;

	// Most bytes written by one little-endian item
	localparam int MAX_LE_BYTES = VALUE_W / BYTE_W;
	localparam int NBYTES_W     = $clog2(MAX_LE_BYTES + 1);

	// Bit accumulator in the back end: partial byte plus one full value
	localparam int ACC_W = VALUE_W + BYTE_W;
	localparam int TOT_W = $clog2(ACC_W + 1);

	// Default depth of the command queue between front and back end
	localparam int QUEUE_DEPTH = 2;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_UNSIGNED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SIGNED   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ALIGN    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LE_BYTES = 2'd3;

	// Command: bits to append, left aligned, with an optional flush first
	typedef struct packed {
		logic               flush;
		logic [VALUE_W-1:0] data;
		logic [WIDTH_W-1:0] bits;
	} cmd_t;

endpackage

// ===== rtl/mfbp_if.sv =====
// Channel interfaces of the bit-field packer: item input and byte result.
// Depends on mfbp_pkg for the field widths.
interface mfbp_item_if;
	import mfbp_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [VALUE_W-1:0] field_value;
	logic [WIDTH_W-1:0] field_width;

	modport source (output valid, kind, field_value, field_width, input ready);
	modport sink   (input valid, kind, field_value, field_width, output ready);
endinterface

interface mfbp_result_if;
	import mfbp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_out;
	logic              last;

	modport source (output valid, byte_out, last, input ready);
	modport sink   (input valid, byte_out, last, output ready);
endinterface

// ===== rtl/mfbp_front.sv =====
// Front end of the bit-field packer: decodes an item into a command word.
// Depends on mfbp_pkg and mfbp_if.
module mfbp_front (
	mfbp_item_if.sink          item,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output mfbp_pkg::cmd_t     cmd
);
	import mfbp_pkg::*;

	logic [WIDTH_W-1:0]  w_eff;
	logic [VALUE_W-1:0]  left;
	logic [VALUE_W-1:0]  swapped;
	logic [VALUE_W-1:0]  keep;
	logic [NBYTES_W-1:0] n_bytes;
	logic [WIDTH_W-1:0]  le_bits;
	logic                is_bits;
	logic                drop;

	// Bit fields: saturate the count and left-align the value
	always_comb begin
		w_eff = (item.field_width > WIDTH_W'(FIELD_LIMIT)) ? WIDTH_W'(FIELD_LIMIT)
			: item.field_width;
		left = item.field_value << (WIDTH_W'(VALUE_W) - w_eff);
		// signed kind forces the top written bit when the value is negative
		if (item.kind == KIND_SIGNED) begin
			left[VALUE_W-1] = left[VALUE_W-1] | item.field_value[VALUE_W-1];
		end
	end

	// Little-endian bytes: low byte goes out first, so it lands on top
	always_comb begin
		for (int i = 0; i < MAX_LE_BYTES; i++) begin
			swapped[VALUE_W-1-BYTE_W*i -: BYTE_W] = item.field_value[BYTE_W*i +: BYTE_W];
		end
		if (item.kind == KIND_ALIGN) begin
			n_bytes = '0;
		end else if (item.field_width > WIDTH_W'(MAX_LE_BYTES)) begin
			n_bytes = NBYTES_W'(MAX_LE_BYTES);
		end else begin
			n_bytes = NBYTES_W'(item.field_width);
		end
		le_bits = WIDTH_W'(n_bytes) << $clog2(BYTE_W);
		// keep only the bytes written, so nothing leaks into the partial byte
		keep = ~({VALUE_W{1'b1}} >> le_bits);
	end

	// Command word
	always_comb begin
		is_bits = (item.kind == KIND_UNSIGNED) || (item.kind == KIND_SIGNED);
		if (is_bits) begin
			cmd.flush = 1'b0;
			cmd.data  = left;
			cmd.bits  = w_eff;
		end else begin
			cmd.flush = 1'b1;
			cmd.data  = swapped & keep;
			cmd.bits  = le_bits;
		end
		// an empty bit field changes nothing
		drop = is_bits && (w_eff == '0);
	end

	assign cmd_valid  = item.valid && !drop;
	assign item.ready = cmd_ready;

endmodule

// ===== rtl/mfbp_queue.sv =====
// Short command queue between the packer's front and back ends.
// Depends on mfbp_pkg for the command type.
module mfbp_queue #(
	parameter int DEPTH = mfbp_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  mfbp_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output mfbp_pkg::cmd_t pop_data
);
	import mfbp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/mfbp_back.sv =====
// Back end of the bit-field packer: merges commands into the partial byte and sends
// completed bytes one per cycle while result is ready. Depends on mfbp_pkg and mfbp_if.
module mfbp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  mfbp_pkg::cmd_t cmd,
	mfbp_result_if.source  result
);
	import mfbp_pkg::*;

	logic               busy_q;
	logic [ACC_W-1:0]   acc_q;
	logic [TOT_W-1:0]   tot_q;
	logic [BYTE_W-1:0]  pend_q;
	logic [POS_W-1:0]   pos_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_last_q;

	logic [ACC_W-1:0]   load_acc;
	logic [TOT_W-1:0]   load_tot;
	logic [ACC_W-1:0]   cur_acc;
	logic [TOT_W-1:0]   cur_tot;
	logic [ACC_W-1:0]   next_acc;
	logic [TOT_W-1:0]   next_tot;
	logic               slot_free;
	logic               has_byte;
	logic               emit;
	logic               settle;
	logic               finishing;

	// Merge the head command behind the partial byte
	always_comb begin
		if (cmd.flush && (pos_q != '0)) begin
			// zero-filled partial byte goes out whole ahead of the data
			load_acc = {pend_q, cmd.data};
			load_tot = TOT_W'(BYTE_W) + TOT_W'(cmd.bits);
		end else begin
			load_acc = {pend_q, VALUE_W'(0)} | ({cmd.data, BYTE_W'(0)} >> pos_q);
			load_tot = TOT_W'(pos_q) + TOT_W'(cmd.bits);
		end
	end

	// Byte selection and progress
	always_comb begin
		cur_acc   = busy_q ? acc_q : load_acc;
		cur_tot   = busy_q ? tot_q : load_tot;
		next_acc  = cur_acc << BYTE_W;
		next_tot  = cur_tot - TOT_W'(BYTE_W);
		slot_free = !out_valid_q || result.ready;
		has_byte  = (cur_tot >= TOT_W'(BYTE_W));
		emit      = (busy_q || pop_valid) && has_byte && slot_free;
		settle    = !busy_q && pop_valid && !has_byte;
		finishing = (next_tot < TOT_W'(BYTE_W));
		pop_ready = !busy_q && (!has_byte || slot_free);
	end

	// Control and partial-byte state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				busy_q <= !finishing;
				if (finishing) begin
					pend_q <= next_acc[ACC_W-1 -: BYTE_W];
					pos_q  <= next_tot[POS_W-1:0];
				end
			end else if (settle) begin
				pend_q <= cur_acc[ACC_W-1 -: BYTE_W];
				pos_q  <= cur_tot[POS_W-1:0];
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Accumulator and output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			acc_q      <= next_acc;
			tot_q      <= next_tot;
			out_byte_q <= cur_acc[ACC_W-1 -: BYTE_W];
			out_last_q <= finishing;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.byte_out = out_byte_q;
	assign result.last     = out_last_q;

endmodule

// ===== rtl/msb_first_bit_field_packer_unit.sv =====
// MSB-first bit-field packer. Items append 1 to 32 bits (unsigned, or signed
// with the top written bit forced when the value is negative), flush the
// partial byte zero-filled, or flush and then write 0 to 4 bytes low byte
// first. Completed bytes leave on the result channel, last marking the final
// byte of each item; an item that completes no byte gives no result. The item
// channel takes one item per cycle while the command queue has room. The back
// end sends one byte per cycle while the result channel accepts it, and an item
// completes at most five bytes, for a flush followed by four bytes; the
// byte-wide result port sets the sustained rate. The first byte of an item
// passes through the command queue and then the output register before it is
// presented on the result channel.
// Depends on mfbp_pkg, mfbp_if, mfbp_front, mfbp_queue and mfbp_back.
module msb_first_bit_field_packer_unit #(
	parameter int QUEUE_DEPTH = mfbp_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	mfbp_item_if.sink     item,
	mfbp_result_if.source result
);
	import mfbp_pkg::*;

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// Decode
	mfbp_front u_front (
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Decoupling queue
	mfbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cmd_valid),
		.push_ready (cmd_ready),
		.push_data  (cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_cmd)
	);

	// Byte assembly and output
	mfbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.cmd       (pop_cmd),
		.result    (result)
	);

endmodule

// ===== rtl/mfbp_checker.sv =====
// Port-level checks for the bit-field packer, bound to the top level.
// Depends on msb_first_bit_field_packer_unit and its channel interfaces.
module mfbp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] byte_out,
	input logic       last
);

	logic seen_q;

	// Remembers that at least one item has been transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (item_valid && item_ready) begin
			seen_q <= 1'b1;
		end
	end

	// A stalled result holds its byte
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(byte_out) && $stable(last))
		else $error("stalled result changed");

	// Reset empties the output register
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	// Queue is empty after reset, so items are taken at once
	a_ready_after_reset: assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> item_ready)
		else $error("item channel not ready after reset");

	// No byte without an item behind it
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> seen_q)
		else $error("result before any item");

endmodule

bind msb_first_bit_field_packer_unit mfbp_checker u_mfbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.byte_out     (result.byte_out),
	.last         (result.last)
);
